/* rtl/xpfec_pkg.sv */
// Shared types and constants for the XOR parity FEC encoder.
package xpfec_pkg;

	// Group marker held before the first packet has been seen.
	localparam logic [15:0] NO_GROUP = 16'hFFFF;

	// Result kinds carried on item_kind.
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_PARITY = 1'b1;

	// Commands from the controller to the datapath, at most one per cycle.
	typedef struct packed {
		logic accept;     // take an input word and read its parity slot
		logic div1;       // reciprocal multiply, estimate of the group
		logic div2;       // back-multiply, remainder estimate
		logic div3;       // correct quotient, update group and restart flag
		logic emit_data;  // update parity slot and load the data result
		logic par_read;   // read the next parity slot
		logic emit_par;   // load a parity result
	} xpfec_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pos_zero;   // next input word opens a packet
		logic group_end;  // current word is the last of a group's last packet
		logic out_free;   // the result register can take a word this cycle
		logic par_last;   // parity index is on the final slot
	} xpfec_sts_t;

endpackage

/* rtl/xpfec_ctrl.sv */
// Controller state machine for the XOR parity FEC encoder.
module xpfec_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  xpfec_pkg::xpfec_sts_t sts,
	output xpfec_pkg::xpfec_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV1,
		S_DIV2,
		S_DIV3,
		S_WORD,
		S_PREAD,
		S_PEMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_stall_q;

	// Commands and next state follow from the current state and status.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.pos_zero ? S_DIV1 : S_WORD;
				end
			end
			S_DIV1: begin
				cmd.div1 = 1'b1;
				state_d  = S_DIV2;
			end
			S_DIV2: begin
				cmd.div2 = 1'b1;
				state_d  = S_DIV3;
			end
			S_DIV3: begin
				cmd.div3 = 1'b1;
				state_d  = S_WORD;
			end
			S_WORD: begin
				if (sts.out_free) begin
					cmd.emit_data = 1'b1;
					state_d       = sts.group_end ? S_PREAD : S_IDLE;
				end
			end
			S_PREAD: begin
				cmd.par_read = 1'b1;
				state_d      = S_PEMIT;
			end
			S_PEMIT: begin
				if (sts.out_free) begin
					cmd.emit_par = 1'b1;
					state_d      = sts.par_last ? S_IDLE : S_PREAD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and the registered stall towards the sender.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_stall_q <= (state_d != S_IDLE);
		end
	end

	assign in_stall = in_stall_q;

`ifndef SYNTH
	// Only one datapath command is issued in any cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.div1, cmd.div2, cmd.div3,
			cmd.emit_data, cmd.par_read, cmd.emit_par}))
		else $error("xpfec_ctrl: more than one command in a cycle");

	// A result is only loaded when the result register has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_data || cmd.emit_par) |-> sts.out_free)
		else $error("xpfec_ctrl: result loaded into a full register");

	// After a parity read the next cycle is spent in the emit state for that slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.par_read |=> (state_q == S_PEMIT))
		else $error("xpfec_ctrl: parity read not followed by emit");
`endif

endmodule

/* rtl/xpfec_dp.sv */
// Datapath for the XOR parity FEC encoder: group divider, parity store, result register.
module xpfec_dp #(
	parameter int unsigned PAYLOAD_WORDS = 16,
	parameter int unsigned GROUP_SIZE    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  xpfec_pkg::xpfec_cmd_t cmd,
	output xpfec_pkg::xpfec_sts_t sts,
	input  logic [31:0]           sequence_number,
	input  logic [63:0]           payload_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           out_sequence,
	output logic [15:0]           group_number,
	output logic                  item_kind,
	output logic [63:0]           out_word,
	output logic                  packet_end,
	output logic                  run_last
);

	localparam int unsigned PosW  = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
	localparam int unsigned LogG  = $clog2(GROUP_SIZE);
	localparam int unsigned RemW  = LogG + 1;
	localparam int unsigned Shift = 31 + LogG;
	localparam logic [63:0] Recip = (64'd1 << Shift) / GROUP_SIZE;
	localparam logic [PosW-1:0] LastPos = PosW'(PAYLOAD_WORDS - 1);

	// Packet tracking.
	logic [PosW-1:0] pos_q;
	logic [PosW-1:0] par_idx_q;
	logic [31:0]     seq_q;
	logic [63:0]     word_q;
	logic [15:0]     group_q;
	logic            restart_q;
	logic            rem_last_q;
	logic [31:0]     first_seq_q;

	// Divider intermediates.
	logic [31:0]     q0_q;
	logic [RemW-1:0] rem0_q;
	logic [63:0]     recip_prod;
	logic [31:0]     back_prod;
	logic            rem_corr;
	logic [31:0]     quot;
	logic [RemW-1:0] rem;

	// Parity store and its read port.
	logic [63:0]              mem_q [PAYLOAD_WORDS];
	logic [PAYLOAD_WORDS-1:0] vld_q;
	logic [63:0]              rd_q;
	logic                     rd_vld_q;
	logic                     rd_en;
	logic [PosW-1:0]          rd_addr;
	logic [63:0]              rd_word;
	logic [63:0]              wr_word;

	// Result register.
	logic        out_valid_q;
	logic [31:0] out_seq_q;
	logic [15:0] out_grp_q;
	logic        out_kind_q;
	logic [63:0] out_word_q;
	logic        out_pend_q;
	logic        out_last_q;

	logic last_word;

	// Status towards the controller.
	assign last_word     = (pos_q == LastPos);
	assign sts.pos_zero  = (pos_q == '0);
	assign sts.group_end = last_word && rem_last_q;
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.par_last  = (par_idx_q == LastPos);

	// Group number by reciprocal multiply, estimate is low by at most one.
	assign recip_prod = {32'd0, seq_q} * {32'd0, Recip[31:0]};
	assign back_prod  = q0_q * 32'(GROUP_SIZE);
	assign rem_corr   = (rem0_q >= RemW'(GROUP_SIZE));
	assign quot       = q0_q + {31'd0, rem_corr};
	assign rem        = rem_corr ? (rem0_q - RemW'(GROUP_SIZE)) : rem0_q;

	// Slots never written read as zero.
	assign rd_word = rd_vld_q ? rd_q : 64'd0;
	assign wr_word = restart_q ? word_q : (word_q ^ rd_word);
	assign rd_en   = cmd.accept || cmd.par_read;
	assign rd_addr = cmd.accept ? pos_q : par_idx_q;

	// Control state of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			par_idx_q  <= '0;
			group_q    <= xpfec_pkg::NO_GROUP;
			restart_q  <= 1'b0;
			rem_last_q <= 1'b0;
			seq_q      <= '0;
		end else begin
			if (cmd.accept && (pos_q == '0)) begin
				seq_q <= sequence_number;
			end
			if (cmd.div3) begin
				restart_q  <= (quot[15:0] != group_q);
				group_q    <= quot[15:0];
				rem_last_q <= (rem == RemW'(GROUP_SIZE - 1));
			end
			if (cmd.emit_data) begin
				pos_q <= last_word ? '0 : pos_q + 1'b1;
			end
			if (cmd.emit_par) begin
				par_idx_q <= sts.par_last ? '0 : par_idx_q + 1'b1;
			end
		end
	end

	// Payload and divider registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			word_q <= payload_word;
		end
		if (cmd.div1) begin
			q0_q <= 32'(recip_prod >> Shift);
		end
		if (cmd.div2) begin
			rem0_q <= RemW'(seq_q - back_prod);
		end
		if (cmd.emit_data) begin
			first_seq_q <= 32'(group_q) * 32'(GROUP_SIZE);
		end
	end

	// Parity store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.emit_data) begin
			mem_q[pos_q] <= wr_word;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Written flags for the parity slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.emit_data) begin
				vld_q[pos_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_data || cmd.emit_par) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded only when the register is free.
	always_ff @(posedge clk) begin
		if (cmd.emit_data) begin
			out_seq_q  <= seq_q;
			out_grp_q  <= group_q;
			out_kind_q <= xpfec_pkg::KIND_DATA;
			out_word_q <= word_q;
			out_pend_q <= last_word;
			out_last_q <= !sts.group_end;
		end else if (cmd.emit_par) begin
			out_seq_q  <= first_seq_q;
			out_grp_q  <= group_q;
			out_kind_q <= xpfec_pkg::KIND_PARITY;
			out_word_q <= rd_word;
			out_pend_q <= sts.par_last;
			out_last_q <= sts.par_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_sequence = out_seq_q;
	assign group_number = out_grp_q;
	assign item_kind    = out_kind_q;
	assign out_word     = out_word_q;
	assign packet_end   = out_pend_q;
	assign run_last     = out_last_q;

`ifndef SYNTH
	// The reciprocal estimate leaves a remainder below twice the group size.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div3 |-> ((RemW + 1)'(rem0_q) < (RemW + 1)'(2 * GROUP_SIZE)))
		else $error("xpfec_dp: remainder estimate out of range");

	// A parity burst always starts from the first slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_data && sts.group_end) |=> (par_idx_q == '0))
		else $error("xpfec_dp: parity burst does not start at slot zero");

	// The last word of a packet brings the word position back to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_data && last_word) |=> (pos_q == '0))
		else $error("xpfec_dp: word position not wrapped after last word");
`endif

endmodule

/* rtl/xor_parity_fec_encoder_unit.sv */
// Top level of the XOR parity FEC encoder: controller plus datapath.
//
// Input channel (in_valid/in_stall) carries one payload word per transfer;
// packets are runs of PAYLOAD_WORDS words, and sequence_number is sampled on
// the first word of each packet only. Output channel (out_valid/out_stall)
// carries data words and parity words, tagged by item_kind.
// Every input word yields one data word. The word that closes the last
// packet of a group is followed by a parity packet of PAYLOAD_WORDS words.
// The data word for the first word of a packet passes through the three-step
// group divider (DIV1, DIV2, DIV3) before it is loaded into the result
// register; other words go from acceptance straight to the result register.
// A new word is taken only once the last one's data word is loaded, and
// each parity word is read from the parity store and then loaded into the
// result register, the load waiting while the result register is full.
// Reset clears the controller, the word position and the parity store's
// written flags, so all slots read as zero; the group is set to no group.
// While the receiver stalls, the result register holds its word and the
// block stops at the next result; it raises in_stall while busy.
module xor_parity_fec_encoder_unit #(
	parameter int unsigned PAYLOAD_WORDS = 16,
	parameter int unsigned GROUP_SIZE    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sequence_number,
	input  logic [63:0] payload_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_sequence,
	output logic [15:0] group_number,
	output logic        item_kind,
	output logic [63:0] out_word,
	output logic        packet_end,
	output logic        run_last
);

	xpfec_pkg::xpfec_cmd_t cmd;
	xpfec_pkg::xpfec_sts_t sts;

	// Sequencing of each word and of the parity burst.
	xpfec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Divider, parity store and result register.
	xpfec_dp #(
		.PAYLOAD_WORDS (PAYLOAD_WORDS),
		.GROUP_SIZE    (GROUP_SIZE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.sequence_number (sequence_number),
		.payload_word    (payload_word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_sequence    (out_sequence),
		.group_number    (group_number),
		.item_kind       (item_kind),
		.out_word        (out_word),
		.packet_end      (packet_end),
		.run_last        (run_last)
	);

endmodule
